// ===== src/psv_pkg.sv =====
// psv_pkg: shared constants and types for the streaming 3D prefix sum block.
// No dependencies; used by psv_pos and prefix_sum_3d_stream_unit.
`default_nettype none

package psv_pkg;

  // Fixed field widths
  localparam int ELEM_W    = 16;
  localparam int SUM_W     = 32;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int LAYERS_W  = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd2;

  // Position status of the request at the head of the stream
  typedef struct packed {
    logic col_zero;
    logic row_zero;
    logic layer_zero;
    logic vol_last;
  } pos_flags_t;

endpackage

`default_nettype wire

// ===== src/psv_pos.sv =====
// psv_pos: configuration registers, dimension clamping and raster position counter.
// Depends on psv_pkg.
`default_nettype none

module psv_pos #(
  parameter int MAX_LAYERS = 16,
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [psv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [psv_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           step,
  output logic      [CW-1:0]                  col_o,
  output logic      [RW-1:0]                  row_o,
  output psv_pkg::pos_flags_t                 flags_o
);

  logic [psv_pkg::LAYERS_W-1:0] layers_r;
  logic [psv_pkg::CFG_W-1:0]    rows_r;
  logic [psv_pkg::CFG_W-1:0]    cols_r;
  logic [LW-1:0] lay_r, lay_nxt, lay_last;
  logic [RW-1:0] row_r, row_nxt, row_last;
  logic [CW-1:0] col_r, col_nxt, col_last;
  logic          at_lay_last, at_row_last, at_col_last;

  // Zero counts as one, oversize counts as the maximum
  always_comb begin
    lay_last = (layers_r == '0) ? '0 :
               ((32'(layers_r) > MAX_LAYERS) ? LW'(MAX_LAYERS - 1) :
                                               LW'(32'(layers_r) - 32'd1));
    row_last = (rows_r == '0) ? '0 :
               ((32'(rows_r) > MAX_ROWS) ? RW'(MAX_ROWS - 1) :
                                           RW'(32'(rows_r) - 32'd1));
    col_last = (cols_r == '0) ? '0 :
               ((32'(cols_r) > MAX_COLS) ? CW'(MAX_COLS - 1) :
                                           CW'(32'(cols_r) - 32'd1));
  end

  assign at_lay_last = (lay_r == lay_last);
  assign at_row_last = (row_r == row_last);
  assign at_col_last = (col_r == col_last);

  always_comb begin
    lay_nxt = lay_r;
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_we) begin
      lay_nxt = '0;
      row_nxt = '0;
      col_nxt = '0;
    end else if (step) begin
      col_nxt = at_col_last ? '0 : col_r + CW'(1);
      if (at_col_last) begin
        row_nxt = at_row_last ? '0 : row_r + RW'(1);
        if (at_row_last) begin
          lay_nxt = at_lay_last ? '0 : lay_r + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layers_r <= psv_pkg::LAYERS_W'(4);
      rows_r   <= psv_pkg::CFG_W'(4);
      cols_r   <= psv_pkg::CFG_W'(4);
      lay_r    <= '0;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      lay_r <= lay_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_we) begin
        case (cfg_index)
          psv_pkg::REG_LAYERS: layers_r <= cfg_data[psv_pkg::LAYERS_W-1:0];
          psv_pkg::REG_ROWS:   rows_r   <= cfg_data;
          psv_pkg::REG_COLS:   cols_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign col_o              = col_r;
  assign row_o              = row_r;
  assign flags_o.col_zero   = (col_r == '0);
  assign flags_o.row_zero   = (row_r == '0);
  assign flags_o.layer_zero = (lay_r == '0);
  assign flags_o.vol_last   = at_lay_last && at_row_last && at_col_last;

endmodule

`default_nettype wire

// ===== src/prefix_sum_3d_stream_unit.sv =====
// prefix_sum_3d_stream_unit: streaming 3D inclusive prefix sum; needs psv_pkg, psv_pos.
// Path: an accepted request passes the stage 1 and stage 2 registers into the output
// register on out_*. Throughput: one request per cycle unless out_ready stalls, set by
// the single read port and single write port of the row store and of the plane store.
// Reset: control, position and configuration (4 x 4 x 4) clear; the stores are not
// cleared and need no pass, since each entry is written before its read data is used.
`default_nettype none

module prefix_sum_3d_stream_unit #(
  parameter int MAX_LAYERS = 16,
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic        [psv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [psv_pkg::CFG_W-1:0]     cfg_data,
  // requests
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [psv_pkg::ELEM_W-1:0]    in_element_value,
  // results
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed      [psv_pkg::SUM_W-1:0]     out_box_sum,
  output logic                                      out_volume_end
);

  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // running row sum: up to MAX_COLS elements
  localparam int RSW     = psv_pkg::ELEM_W + ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 0);
  // in-layer 2D sum: up to MAX_ROWS * MAX_COLS elements, never wider than the result
  localparam int S2W_RAW = psv_pkg::ELEM_W + ((DEPTH > 1) ? $clog2(DEPTH) : 0);
  localparam int S2W     = (S2W_RAW > psv_pkg::SUM_W) ? psv_pkg::SUM_W : S2W_RAW;
  localparam int SW      = psv_pkg::SUM_W;

  // ---------------------------------------------------------------------------
  // Position counter and configuration
  // ---------------------------------------------------------------------------
  logic                accept;
  logic [CW-1:0]       pos_col;
  logic [RW-1:0]       pos_row;
  psv_pkg::pos_flags_t pos_flags;

  psv_pos #(
    .MAX_LAYERS (MAX_LAYERS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .col_o     (pos_col),
    .row_o     (pos_row),
    .flags_o   (pos_flags)
  );

  // ---------------------------------------------------------------------------
  // Stores: row store holds the previous row's 2D sums, plane store the
  // previous layer's 3D sums. One read and one write port each, registered read.
  // ---------------------------------------------------------------------------
  logic signed [S2W-1:0] row_mem [MAX_COLS];
  logic signed [SW-1:0]  plane_mem [DEPTH];
  logic signed [S2W-1:0] row_rd_r;
  logic signed [SW-1:0]  pl_rd_r;

  // Pipeline valid and handshake
  logic out_valid_r;
  logic s1_v_r, s2_v_r;
  logic s1_adv, s2_adv;

  assign s2_adv   = s2_v_r && (!out_valid_r || out_ready);
  assign s1_adv   = s1_v_r && (!s2_v_r || s2_adv);
  assign in_ready = !s1_v_r || s1_adv;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Stage 0 (accept): extend the running row sum, issue the row store read
  // ---------------------------------------------------------------------------
  logic signed [RSW-1:0] rowsum_r, rowsum_nxt, rowsum_base;
  logic [AW-1:0]         s0_addr;

  assign rowsum_base = pos_flags.col_zero ? '0 : rowsum_r;
  assign rowsum_nxt  = rowsum_base + RSW'(in_element_value);
  assign s0_addr     = AW'(32'(pos_row) * MAX_COLS + 32'(pos_col));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowsum_r <= '0;
    end else if (cfg_we) begin
      rowsum_r <= '0;
    end else if (accept) begin
      rowsum_r <= rowsum_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: 2D sum = row sum + previous row's 2D sum; write the row store,
  // issue the plane store read
  // ---------------------------------------------------------------------------
  logic [CW-1:0]         s1_col_r;
  logic [AW-1:0]         s1_addr_r;
  logic signed [RSW-1:0] s1_rowsum_r;
  logic                  s1_rz_r, s1_lz_r, s1_last_r;
  logic                  s1_rfwd_r;
  logic signed [S2W-1:0] s1_rfwd_d_r;
  logic signed [S2W-1:0] s1_row_term, s1_s2;
  logic                  s0_rfwd;

  // The row entry being written at the accepting edge is missed by the read
  assign s0_rfwd     = s1_v_r && s1_adv && (s1_col_r == pos_col);
  assign s1_row_term = s1_rz_r ? '0 : (s1_rfwd_r ? s1_rfwd_d_r : row_rd_r);
  assign s1_s2       = S2W'(s1_rowsum_r) + s1_row_term;

  // ---------------------------------------------------------------------------
  // Stage 2: 3D sum = 2D sum + previous layer's 3D sum; write the plane store
  // ---------------------------------------------------------------------------
  logic [AW-1:0]         s2_addr_r;
  logic signed [S2W-1:0] s2_s2_r;
  logic                  s2_lz_r, s2_last_r;
  logic                  s2_pfwd_r;
  logic signed [SW-1:0]  s2_pfwd_d_r;
  logic signed [SW-1:0]  s2_pl_term, s2_p;
  logic                  s1_pfwd;

  assign s1_pfwd    = s2_v_r && s2_adv && (s2_addr_r == s1_addr_r);
  assign s2_pl_term = s2_lz_r ? '0 : (s2_pfwd_r ? s2_pfwd_d_r : pl_rd_r);
  assign s2_p       = SW'(s2_s2_r) + s2_pl_term;

  // Store ports: read only when a request moves in, so stalled read data holds
  always_ff @(posedge clk) begin
    if (accept) begin
      row_rd_r <= row_mem[pos_col];
    end
    if (s1_adv) begin
      row_mem[s1_col_r] <= s1_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pl_rd_r <= plane_mem[s1_addr_r];
    end
    if (s2_adv) begin
      plane_mem[s2_addr_r] <= s2_p;
    end
  end

  // Payload registers
  logic signed [SW-1:0] out_box_sum_r;
  logic                 out_volume_end_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r    <= pos_col;
      s1_addr_r   <= s0_addr;
      s1_rowsum_r <= rowsum_nxt;
      s1_rz_r     <= pos_flags.row_zero;
      s1_lz_r     <= pos_flags.layer_zero;
      s1_last_r   <= pos_flags.vol_last;
      s1_rfwd_r   <= s0_rfwd;
      s1_rfwd_d_r <= s1_s2;
    end
    if (s1_adv) begin
      s2_addr_r   <= s1_addr_r;
      s2_s2_r     <= s1_s2;
      s2_lz_r     <= s1_lz_r;
      s2_last_r   <= s1_last_r;
      s2_pfwd_r   <= s1_pfwd;
      s2_pfwd_d_r <= s2_p;
    end
    if (s2_adv) begin
      out_box_sum_r    <= s2_p;
      out_volume_end_r <= s2_last_r;
    end
  end

  // Valid bits: advance on handshake, drop when the next stage takes the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_box_sum    = out_box_sum_r;
  assign out_volume_end = out_volume_end_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Any configuration write restarts the volume at the origin
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (pos_flags.col_zero && pos_flags.row_zero && pos_flags.layer_zero))
    else $error("volume did not restart after configuration write");

  // Back-to-back row store hits only happen with a single column
  a_row_fwd_col: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_rfwd_r) |-> (s1_col_r == '0))
    else $error("row store forward on a nonzero column");

  // A stalled last stage holds its request and the stage behind it
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_adv) |=> (s2_v_r && $stable(s2_addr_r) && $stable(s2_s2_r)))
    else $error("stage 2 request lost during stall");

endmodule

`default_nettype wire

// ===== bench/prefix_sum_3d_stream_unit_test.sv =====
`timescale 1ns / 1ps
// prefix_sum_3d_stream_unit_test: self-checking bench for the streaming 3D prefix sum unit.
// Drives requests, configuration and result back-pressure, and predicts every box sum.
// Depends on psv_pkg and prefix_sum_3d_stream_unit.

module prefix_sum_3d_stream_unit_test;

  localparam int DEPTH_LAYERS = 16;
  localparam int DEPTH_ROWS   = 64;
  localparam int DEPTH_COLS   = 64;

  // Index past the last register: no register behind it, but a write still restarts
  localparam logic [psv_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [psv_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [psv_pkg::CFG_W-1:0]         cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic signed [psv_pkg::ELEM_W-1:0] in_element_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [psv_pkg::SUM_W-1:0]  out_box_sum;
  logic                              out_volume_end;

  // Set per phase: enables random gaps on both the request and the result side
  bit idling_on = 1'b0;
  int ready_hold = 0;

  always #1 clk = ~clk;

  prefix_sum_3d_stream_unit #(
    .MAX_LAYERS(DEPTH_LAYERS),
    .MAX_ROWS  (DEPTH_ROWS),
    .MAX_COLS  (DEPTH_COLS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_element_value(in_element_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_box_sum     (out_box_sum),
    .out_volume_end  (out_volume_end)
  );

  // Map a register value onto the dimension actually used: zero acts as one,
  // anything above the buffer depth acts as the depth.
  function automatic int fit_dim(input int value, input int limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  typedef struct {
    int sum;
    bit last;
  } box_result_t;

  // Tracks the volume position and the running sums, and holds the box sums
  // still owed by the block in request order.
  class box_sum_board;
    logic [4:0]  layers_reg;
    logic [6:0]  rows_reg;
    logic [6:0]  cols_reg;
    int          plane_sums [DEPTH_ROWS*DEPTH_COLS];
    int          row_sums [DEPTH_COLS];
    int          row_acc;
    int          layer_pos;
    int          row_pos;
    int          col_pos;
    box_result_t owed_sums [$];
    int          mismatch_count;

    function new();
      layers_reg = 5'd4;
      rows_reg = 7'd4;
      cols_reg = 7'd4;
      mismatch_count = 0;
      restart();
    endfunction

    function void restart();
      row_acc = 0;
      layer_pos = 0;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int pending();
      return owed_sums.size();
    endfunction

    task report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatch_count++;
    endtask

    // Any write, even to the spare index, starts a new volume
    function void set_reg(input logic [psv_pkg::CFG_IDX_W-1:0] idx,
                          input logic [psv_pkg::CFG_W-1:0] data);
      case (idx)
        psv_pkg::REG_LAYERS: layers_reg = data[4:0];
        psv_pkg::REG_ROWS:   rows_reg = data;
        psv_pkg::REG_COLS:   cols_reg = data;
        default: ;
      endcase
      restart();
    endfunction

    // Fold one accepted request into the sums and queue its box sum
    function void note_element(input logic signed [psv_pkg::ELEM_W-1:0] value);
      int          nl;
      int          nr;
      int          nc;
      int          plane_2d;
      int          addr;
      box_result_t res;
      nl = fit_dim(layers_reg, DEPTH_LAYERS);
      nr = fit_dim(rows_reg, DEPTH_ROWS);
      nc = fit_dim(cols_reg, DEPTH_COLS);
      if (layer_pos >= nl) layer_pos = 0;
      if (row_pos >= nr) row_pos = 0;
      if (col_pos >= nc) col_pos = 0;

      if (col_pos == 0) row_acc = 0;
      row_acc += value;
      plane_2d = row_acc + ((row_pos > 0) ? row_sums[col_pos] : 0);
      row_sums[col_pos] = plane_2d;
      addr = row_pos * DEPTH_COLS + col_pos;
      res.sum = plane_2d + ((layer_pos > 0) ? plane_sums[addr] : 0);
      plane_sums[addr] = res.sum;
      res.last = (layer_pos == nl - 1) && (row_pos == nr - 1) && (col_pos == nc - 1);
      owed_sums.push_back(res);

      col_pos++;
      if (col_pos >= nc) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= nr) begin
          row_pos = 0;
          layer_pos++;
          if (layer_pos >= nl) layer_pos = 0;
        end
      end
    endfunction

    task check_result(input logic signed [psv_pkg::SUM_W-1:0] sum, input logic last);
      box_result_t owed;
      if (owed_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result sum=%0d end=%b", sum, last));
        return;
      end
      owed = owed_sums.pop_front();
      if (sum !== owed.sum)
        report_mismatch($sformatf("box_sum %0d, predicted %0d", sum, owed.sum));
      if (last !== owed.last)
        report_mismatch($sformatf("volume_end %b, predicted %b (sum %0d)", last, owed.last,
                                  owed.sum));
    endtask
  endclass

  box_sum_board board = new();

  // Result side: check on every accepted result, then pick the ready level for
  // the next edge. Stalls come in bursts only while idling is enabled.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_box_sum, out_volume_end);
    if (idling_on && ready_hold == 0 && $urandom_range(0, 6) == 0)
      ready_hold = $urandom_range(1, 9);
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one request and hold it until accepted; optionally idle first
  task automatic push_element(input logic signed [psv_pkg::ELEM_W-1:0] value);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_element(value);
  endtask

  // Drop valid and wait until every owed result has come back. Each request
  // yields exactly one result, so an empty queue means the block is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic cfg_write(input logic [psv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psv_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  task automatic program_dims(input int layers, input int rows, input int cols);
    drain_results();
    cfg_write(psv_pkg::REG_LAYERS, layers[psv_pkg::CFG_W-1:0]);
    cfg_write(psv_pkg::REG_ROWS, rows[psv_pkg::CFG_W-1:0]);
    cfg_write(psv_pkg::REG_COLS, cols[psv_pkg::CFG_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  // Restart the volume through the unused register index
  task automatic spare_restart();
    drain_results();
    cfg_write(REG_SPARE, psv_pkg::CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Bias toward the rails and tiny values, else full-range random
  function automatic logic signed [psv_pkg::ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return psv_pkg::ELEM_W'($urandom_range(0, 8) - 4);
      default: return psv_pkg::ELEM_W'($urandom);
    endcase
  endfunction

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int sent;
    int items;
    int vol;
    int l_cfg;
    int r_cfg;
    int c_cfg;
    int waited;
    bit split;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset dimensions (4 x 4 x 4) with rail values
    idling_on = 1'b0;
    push_element(16'sh7FFF);
    push_element(16'sh8000);
    push_element(16'sh0000);
    push_element(-16'sd1);
    push_element(16'sd1);
    push_element(16'sd12345);

    // Directed: restart mid-volume through the spare index
    spare_restart();
    push_element(16'sd100);
    push_element(-16'sd200);
    push_element(16'sd300);
    push_element(-16'sd400);

    // Directed: zero dimensions act as one, so every request ends a volume
    program_dims(0, 0, 0);
    push_element(16'sh7FFF);
    push_element(16'sh8000);
    push_element(-16'sd1);

    // Directed: 2 x 2 x 2 with mixed rail values, ending the volume
    program_dims(2, 2, 2);
    push_element(16'sh7FFF);
    push_element(16'sh8000);
    push_element(16'sh8000);
    push_element(16'sh7FFF);
    push_element(16'sh7FFF);
    push_element(16'sh7FFF);
    push_element(16'sh8000);
    push_element(16'sh7FFF);

    // Random phases: mostly small volumes completed one or more times, with
    // tall, wide and out-of-range settings mixed in
    sent = 0;
    while (sent < 600) begin
      idling_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          l_cfg = $urandom_range(0, 127);
          r_cfg = $urandom_range(0, 127);
          c_cfg = $urandom_range(0, 127);
        end
        1: begin
          l_cfg = $urandom_range(1, 3);
          r_cfg = $urandom_range(16, 64);
          c_cfg = $urandom_range(1, 2);
        end
        2: begin
          l_cfg = $urandom_range(1, 2);
          r_cfg = $urandom_range(1, 2);
          c_cfg = $urandom_range(16, 64);
        end
        default: begin
          l_cfg = $urandom_range(0, 4);
          r_cfg = $urandom_range(0, 6);
          c_cfg = $urandom_range(0, 8);
        end
      endcase
      program_dims(l_cfg, r_cfg, c_cfg);
      vol = fit_dim(l_cfg % 32, DEPTH_LAYERS) * fit_dim(r_cfg, DEPTH_ROWS) *
            fit_dim(c_cfg, DEPTH_COLS);
      items = vol * $urandom_range(1, 3);
      if ($urandom_range(0, 1) == 1) items += $urandom_range(0, vol - 1);
      if (items > 150) items = $urandom_range(20, 150);
      split = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < items; k++) begin
        if (split && k == items / 2) spare_restart();
        push_element(pick_element());
      end
      sent += items;
    end

    // Last part, no idling: a full-width 2 x 2 volume, first layer on the high
    // rail and second layer on the low rail. Over-range columns clamp to the depth.
    idling_on = 1'b0;
    program_dims(2, 2, 100);
    repeat (2 * DEPTH_COLS) push_element(16'sh7FFF);
    repeat (2 * DEPTH_COLS) push_element(16'sh8000);

    // Drain with a bound, then let the pipeline settle
    in_valid <= 1'b0;
    waited = 0;
    while (board.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.pending()));

    if (board.mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/psv_pkg.sv
src/psv_pos.sv
src/prefix_sum_3d_stream_unit.sv
bench/prefix_sum_3d_stream_unit_test.sv
